// ===== src/mdr_pkg.sv =====
// Package for the motor drive regulator: request and result structs, state struct
// and shared constants. No dependencies.
package mdr_pkg;

    localparam logic [7:0] DUTY_MAX = 8'd255;
    localparam logic [1:0] SCALE_ROUND = 2'd3;

    typedef struct packed {
        logic       halt;
        logic [7:0] elapsed_ms;
        logic [7:0] speed_goal;
        logic [9:0] sense_sample;
        logic [7:0] ramp_up_ms;
        logic [7:0] ramp_down_ms;
    } mdr_in_t;

    typedef struct packed {
        logic [7:0] duty;
        logic [7:0] pwm_compare;
        logic [7:0] ramped_speed_out;
        logic [8:0] feedback_out;
    } mdr_out_t;

    typedef struct packed {
        logic [15:0] ramp_timer;
        logic [7:0]  ramped_speed;
        logic [7:0]  duty_level;
        logic [8:0]  feedback_avg;
    } mdr_state_t;

endpackage

// ===== src/motor_drive_regulator.sv =====
// Top level of the motor drive regulator: request register, tick logic, state
// and result register. Depends on mdr_pkg and mdr_step.
//
//   Channel   Signals                         Direction
//   request   in_valid, in_ready, in_data     into the block, one tick each
//   result    out_valid, out_ready, out_data  out of the block, one per request
//
// A request is held in the request register and moves into the result register
// when it advances, so one request is taken every cycle while the result side is
// not stalled. State is updated as a request moves into the result register.
// Reset clears the state and both valid flags. A stalled result holds the request
// register, which then fills and drops in_ready.
module motor_drive_regulator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mdr_pkg::mdr_in_t   in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output mdr_pkg::mdr_out_t  out_data
);
    import mdr_pkg::*;

    logic       req_valid_reg;
    mdr_in_t    req_reg;
    logic       res_valid_reg;
    mdr_out_t   res_reg;
    mdr_state_t state_reg;
    mdr_state_t state_next;
    mdr_out_t   res_next;
    logic       advance;

    mdr_step u_step (
        .req       (req_reg),
        .state_cur (state_reg),
        .state_nxt (state_next),
        .result    (res_next)
    );

    assign advance   = req_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready  = !req_valid_reg || advance;
    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                req_valid_reg <= in_valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg <= in_data;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

endmodule

// ===== src/mdr_step.sv =====
// One control tick of the regulator as combinational logic: feedback filter,
// duty adjustment and speed ramp. Depends on mdr_pkg.
module mdr_step (
    input  mdr_pkg::mdr_in_t    req,
    input  mdr_pkg::mdr_state_t state_cur,
    output mdr_pkg::mdr_state_t state_nxt,
    output mdr_pkg::mdr_out_t   result
);
    import mdr_pkg::*;

    logic [15:0] timer_base;
    logic [7:0]  speed_base;
    logic [7:0]  duty_base;
    logic [10:0] sample_round;
    logic [8:0]  sample_scaled;
    logic [9:0]  fb_sum;
    logic [8:0]  fb_new;
    logic [8:0]  err_up;
    logic [7:0]  inc;
    logic [8:0]  duty_sum;
    logic [8:0]  err_down;
    logic [7:0]  dec;
    logic [7:0]  duty_new;
    logic [15:0] timer_new;
    logic [7:0]  speed_new;

    always_comb
    begin
        timer_base = req.halt ? 16'd0 : state_cur.ramp_timer + {8'd0, req.elapsed_ms};
        speed_base = req.halt ? 8'd0 : state_cur.ramped_speed;
        duty_base  = req.halt ? 8'd0 : state_cur.duty_level;

        sample_round  = {1'b0, req.sense_sample} + {9'd0, SCALE_ROUND};
        sample_scaled = sample_round[10:2];
        fb_sum = {1'b0, state_cur.feedback_avg} + {1'b0, sample_scaled} + 10'd1;
        fb_new = fb_sum[9:1];

        err_up   = {1'b0, speed_base} - fb_new;
        inc      = {1'b0, err_up[7:1]} + 8'd1;
        duty_sum = {1'b0, duty_base} + {1'b0, inc};
        err_down = fb_new - {1'b0, speed_base};
        dec      = err_down[8:1] + 8'd1;

        if (fb_new < {1'b0, speed_base})
        begin
            duty_new = duty_sum[8] ? DUTY_MAX : duty_sum[7:0];
        end
        else if (fb_new > {1'b0, speed_base})
        begin
            duty_new = (dec >= duty_base) ? 8'd0 : duty_base - dec;
        end
        else
        begin
            duty_new = duty_base;
        end

        timer_new = timer_base;
        speed_new = speed_base;
        if (!req.halt)
        begin
            if (speed_base < req.speed_goal)
            begin
                if (timer_base >= {8'd0, req.ramp_up_ms})
                begin
                    speed_new = speed_base + 8'd1;
                    timer_new = timer_base - {8'd0, req.ramp_up_ms};
                end
            end
            else if (speed_base > req.speed_goal)
            begin
                if (timer_base >= {8'd0, req.ramp_down_ms})
                begin
                    speed_new = speed_base - 8'd1;
                    timer_new = timer_base - {8'd0, req.ramp_down_ms};
                end
            end
            else
            begin
                timer_new = 16'd0;
            end
        end

        state_nxt.ramp_timer   = timer_new;
        state_nxt.ramped_speed = speed_new;
        state_nxt.duty_level   = duty_new;
        state_nxt.feedback_avg = fb_new;

        result.duty             = duty_new;
        result.pwm_compare      = DUTY_MAX - duty_new;
        result.ramped_speed_out = speed_new;
        result.feedback_out     = fb_new;
    end

endmodule

// ===== verif/mdr_checker.sv =====
`timescale 1ns / 1ps
// Checker for the motor drive regulator: watches both channels, predicts each result
// from the accepted requests and compares field by field. Depends on mdr_pkg.
module mdr_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  mdr_pkg::mdr_in_t  in_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  mdr_pkg::mdr_out_t out_data,
    output int                mismatch_count,
    output int                ticks_checked,
    output int                ticks_pending
);
    import mdr_pkg::*;

    logic [15:0] ramp_clock;
    logic [7:0]  speed_now;
    logic [7:0]  duty_now;
    logic [8:0]  volt_avg;
    mdr_out_t    expected_drive[$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: result %0d %s is %0d, expected %0d",
                 $time, ticks_checked, what, got, want);
        mismatch_count++;
    endtask

    task automatic regulate_tick(input mdr_in_t req, output mdr_out_t res);
        int fb;
        int sp;
        int d;
        int step;
        if (req.halt) begin
            ramp_clock = '0;
            speed_now  = '0;
            duty_now   = '0;
        end
        else begin
            ramp_clock = ramp_clock + 16'(req.elapsed_ms);
        end
        fb = (int'(volt_avg) + ((int'(req.sense_sample) + 3) >> 2) + 1) >> 1;
        sp = int'(speed_now);
        d  = int'(duty_now);
        volt_avg = fb[8:0];
        if (fb < sp) begin
            d = d + ((sp - fb) >> 1) + 1;
            if (d > 255)
                d = 255;
        end
        else if (fb > sp) begin
            step = ((fb - sp) >> 1) + 1;
            d = (step >= d) ? 0 : d - step;
        end
        duty_now = d[7:0];
        if (!req.halt) begin
            if (speed_now < req.speed_goal) begin
                if (ramp_clock >= 16'(req.ramp_up_ms)) begin
                    speed_now  = speed_now + 8'd1;
                    ramp_clock = ramp_clock - 16'(req.ramp_up_ms);
                end
            end
            else if (speed_now > req.speed_goal) begin
                if (ramp_clock >= 16'(req.ramp_down_ms)) begin
                    speed_now  = speed_now - 8'd1;
                    ramp_clock = ramp_clock - 16'(req.ramp_down_ms);
                end
            end
            else begin
                ramp_clock = '0;
            end
        end
        res.duty             = duty_now;
        res.pwm_compare      = DUTY_MAX - duty_now;
        res.ramped_speed_out = speed_now;
        res.feedback_out     = volt_avg;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        mdr_out_t fresh;
        mdr_out_t want;
        if (!rst_n) begin
            ramp_clock     = '0;
            speed_now      = '0;
            duty_now       = '0;
            volt_avg       = '0;
            mismatch_count = 0;
            ticks_checked  = 0;
            ticks_pending  = 0;
            expected_drive.delete();
        end
        else begin
            if (in_valid && in_ready) begin
                regulate_tick(in_data, fresh);
                expected_drive.push_back(fresh);
            end
            if (out_valid && out_ready) begin
                if (expected_drive.size() == 0) begin
                    report_mismatch("result without a pending request", 1, 0);
                end
                else begin
                    want = expected_drive.pop_front();
                    if (out_data.duty !== want.duty)
                        report_mismatch("duty", out_data.duty, want.duty);
                    if (out_data.pwm_compare !== want.pwm_compare)
                        report_mismatch("pwm_compare", out_data.pwm_compare,
                                        want.pwm_compare);
                    if (out_data.ramped_speed_out !== want.ramped_speed_out)
                        report_mismatch("ramped_speed_out", out_data.ramped_speed_out,
                                        want.ramped_speed_out);
                    if (out_data.feedback_out !== want.feedback_out)
                        report_mismatch("feedback_out", out_data.feedback_out,
                                        want.feedback_out);
                end
                ticks_checked++;
            end
            ticks_pending = expected_drive.size();
        end
    end

endmodule

// ===== verif/motor_drive_regulator_tb.sv =====
`timescale 1ns / 1ps
// Top of the motor drive regulator testbench: clock, reset, request stimulus with
// bursts and gaps, result-side stalls and the verdict. Depends on mdr_pkg, mdr_checker and the DUT.
module motor_drive_regulator_tb;
    import mdr_pkg::*;

    localparam int RANDOM_TICKS = 1200;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    mdr_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    mdr_out_t out_data;

    int mismatch_count;
    int ticks_checked;
    int ticks_pending;
    int ticks_sent;
    int directed_sent;
    int burst_left;

    motor_drive_regulator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    mdr_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .mismatch_count(mismatch_count),
        .ticks_checked (ticks_checked),
        .ticks_pending (ticks_pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("Run timed out with %0d results still pending", ticks_pending);
        $display("Mismatches found");
        $finish;
    end

    function automatic mdr_in_t tick(input logic h, input int el, input int tgt,
                                     input int smp, input int up, input int dn);
        mdr_in_t req;
        req.halt         = h;
        req.elapsed_ms   = el[7:0];
        req.speed_goal   = tgt[7:0];
        req.sense_sample = smp[9:0];
        req.ramp_up_ms   = up[7:0];
        req.ramp_down_ms = dn[7:0];
        return req;
    endfunction

    function automatic int pick_interval();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 255;
            2:       return $urandom_range(1, 16);
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    task automatic offer_tick(input mdr_in_t req);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        in_data  <= req;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
        ticks_sent++;
    endtask

    initial begin
        int seg;
        int mode;
        int span;
        int i;
        out_ready = 1'b0;
        @(posedge rst_n);
        seg = 0;
        forever begin
            span = $urandom_range(10, 150);
            mode = $urandom_range(0, 3);
            if (seg == 6) begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else begin
                for (i = 0; i < span; i++) begin
                    case (mode)
                        0:       out_ready <= 1'b1;
                        1:       out_ready <= 1'($urandom_range(0, 1));
                        2:       out_ready <= ($urandom_range(0, 7) == 0);
                        default: out_ready <= ($urandom_range(0, 7) != 0);
                    endcase
                    @(posedge clk);
                end
            end
            seg++;
        end
    end

    initial begin
        int seg_len;
        int tgt;
        int up;
        int dn;
        int base;
        int smp;
        int el;
        int k;
        bit noisy;
        in_valid   = 1'b0;
        in_data    = '0;
        rst_n      = 1'b0;
        ticks_sent = 0;
        burst_left = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        offer_tick(tick(1'b0, 0, 0, 0, 0, 0));
        offer_tick(tick(1'b0, 255, 255, 1023, 255, 255));
        offer_tick(tick(1'b1, 255, 255, 1023, 255, 255));
        offer_tick(tick(1'b1, 0, 0, 0, 0, 0));
        for (k = 0; k < 8; k++)
            offer_tick(tick(1'b0, 0, 255, 0, 0, 0));
        offer_tick(tick(1'b0, 255, 255, 1023, 255, 0));
        for (k = 0; k < 4; k++)
            offer_tick(tick(1'b0, 0, 0, 1023, 0, 0));
        offer_tick(tick(1'b0, 255, 0, 3, 0, 255));
        offer_tick(tick(1'b0, 255, 0, 1020, 255, 255));
        offer_tick(tick(1'b0, 1, 3, 1, 10, 10));
        offer_tick(tick(1'b0, 2, 3, 2, 10, 10));
        offer_tick(tick(1'b0, 200, 3, 512, 100, 100));
        offer_tick(tick(1'b0, 7, 3, 700, 5, 5));
        directed_sent = ticks_sent;

        while (ticks_sent < directed_sent + RANDOM_TICKS) begin
            seg_len = $urandom_range(5, 60);
            tgt     = $urandom_range(0, 255);
            up      = pick_interval();
            dn      = pick_interval();
            base    = $urandom_range(0, 1023);
            noisy   = ($urandom_range(0, 7) == 0);
            for (k = 0; k < seg_len; k++) begin
                if (noisy) begin
                    offer_tick(tick(1'($urandom_range(0, 1)), $urandom_range(0, 255),
                                    $urandom_range(0, 255), $urandom_range(0, 1023),
                                    $urandom_range(0, 255), $urandom_range(0, 255)));
                end
                else begin
                    el = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 20)
                                                    : $urandom_range(0, 255);
                    if ($urandom_range(0, 9) == 0)
                        smp = $urandom_range(0, 1023);
                    else
                        smp = base + $urandom_range(0, 64) - 32;
                    if (smp < 0)
                        smp = 0;
                    if (smp > 1023)
                        smp = 1023;
                    if ($urandom_range(0, 9) == 0)
                        tgt = $urandom_range(0, 255);
                    offer_tick(tick(($urandom_range(0, 49) == 0), el, tgt, smp, up, dn));
                end
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);

        while (ticks_pending != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);

        $display("Drove %0d ticks (%0d directed, the rest in random ramp segments).",
                 ticks_sent, directed_sent);
        $display("Checked %0d results under bursty requests and result stalls.",
                 ticks_checked);
        if (mismatch_count == 0 && ticks_pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
src/mdr_pkg.sv
src/mdr_step.sv
src/motor_drive_regulator.sv
verif/mdr_checker.sv
verif/motor_drive_regulator_tb.sv
